[rtl/atw_pkg.sv]
// Shared types, constants and table helpers for the asymmetric tanh waveshaper.
package atw_pkg;

  // Field and datapath widths
  localparam int unsigned SampleInW  = 18;  // signed Q2.15 input
  localparam int unsigned SampleOutW = 17;  // signed Q1.15 output
  localparam int unsigned GainW      = 16;  // register width
  localparam int unsigned MagW       = 16;  // |x| for x in [-1, +1]
  localparam int unsigned ProdW      = 32;  // gain * magnitude
  localparam int unsigned ArgW       = 23;  // tanh argument, Q15
  localparam int unsigned SpanShift  = 18;  // tanh span [0,8) in Q15
  localparam int unsigned TanhW      = 16;  // tanh value, Q15, up to one
  localparam int unsigned DiffProdW  = TanhW + SpanShift;
  localparam int unsigned NormProdW  = TanhW + GainW;
  localparam int unsigned CfgAddrW   = 1;
  localparam int unsigned TdataInW   = 24;
  localparam int unsigned TdataOutW  = 24;

  localparam logic [TanhW-1:0] OneQ15 = 16'd32768;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_DRIVE_GAIN = 1'b0,
    CFG_NORM_SCALE = 1'b1
  } atw_cfg_e;

  // Sample class, decided at the input and carried down the pipe
  typedef struct packed {
    logic clip_pos;  // above +1
    logic clip_neg;  // below -1
    logic is_zero;
    logic is_pos;    // positive, above zero
  } atw_flags_t;

  // Restoring divide, used only while building the tanh table
  function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                             input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(8k/segs) in Q15: e^-v by series, raised to the 16th, then (1-q)/(1+q)
  function automatic logic [TanhW-1:0] tanh_point(input int unsigned k,
                                                  input int unsigned segs);
    logic [63:0] q30;
    logic [63:0] term;
    logic [63:0] ev;
    logic [63:0] q;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] res;
    q30  = 64'd1 << 30;
    term = q30;
    ev   = q30;
    for (int unsigned i = 1; i < 24; i++) begin
      term = const_udiv(term * 64'(k), 64'(segs) * 64'(i));
      ev   = ev + term;
    end
    q = const_udiv((64'd1 << 60) + (ev >> 1), ev);
    for (int s = 0; s < 4; s++) begin
      q = (q * q + (64'd1 << 29)) >> 30;
    end
    num = ((q30 - q) << 15) + ((q30 + q) >> 1);
    den = q30 + q;
    res = const_udiv(num, den);
    return res[TanhW-1:0];
  endfunction

endpackage

[rtl/atw_drive.sv]
// Input stages: classify the sample, apply drive gain, split into table segment and fraction.
module atw_drive #(
  parameter int unsigned Segments = 64,
  localparam int unsigned SegW = $clog2(Segments)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [atw_pkg::SampleInW-1:0]   sample_i,
  input  logic [atw_pkg::GainW-1:0]              drive_gain_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [SegW-1:0]                        seg_o,
  output logic [atw_pkg::SpanShift-1:0]          frac_o,
  output logic                                   big_o,
  output atw_pkg::atw_flags_t                    flags_o
);

  localparam int unsigned PW = SegW + atw_pkg::SpanShift;
  localparam logic [PW-1:0] SegsP = PW'(Segments);

  // Stage handshake: each stage moves when it is empty or its successor moves
  logic va_q, vb_q;
  logic adv_a, adv_b;

  assign adv_b   = !vb_q || ready_i;
  assign adv_a   = !va_q || adv_b;
  assign ready_o = adv_a;
  assign valid_o = vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= valid_i;
      if (adv_b) vb_q <= va_q;
    end
  end

  // Stage A: classify and multiply magnitude by drive gain
  atw_pkg::atw_flags_t flags_a;
  logic signed [atw_pkg::SampleInW-1:0] neg_x;
  logic [atw_pkg::MagW-1:0]  mag_a;
  logic [atw_pkg::ProdW-1:0] prod_a;

  always_comb begin
    flags_a.clip_pos = sample_i > 18'sd32768;
    flags_a.clip_neg = sample_i < -18'sd32768;
    flags_a.is_zero  = sample_i == '0;
    flags_a.is_pos   = sample_i > 18'sd0;
    neg_x            = -sample_i;
    mag_a            = flags_a.is_pos ? sample_i[atw_pkg::MagW-1:0]
                                      : neg_x[atw_pkg::MagW-1:0];
    prod_a           = {16'b0, drive_gain_i} * {16'b0, mag_a};
  end

  atw_pkg::atw_flags_t       flags_a_q;
  logic [atw_pkg::MagW-1:0]  mag_q;
  logic [atw_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (adv_a && valid_i) begin
      flags_a_q <= flags_a;
      mag_q     <= mag_a;
      prod_q    <= prod_a;
    end
  end

  // Stage B: round the drive argument, locate segment
  logic [atw_pkg::ProdW-1:0] rnd_b;
  logic [atw_pkg::ArgW-1:0]  arg_b;
  logic                      big_b;
  logic [PW-1:0]             pos_b;

  always_comb begin
    rnd_b = prod_q + 32'd128;
    arg_b = flags_a_q.is_pos ? rnd_b[30:8] : {7'b0, mag_q};
    big_b = |arg_b[atw_pkg::ArgW-1:atw_pkg::SpanShift];
    pos_b = PW'(arg_b[atw_pkg::SpanShift-1:0]) * SegsP;
  end

  always_ff @(posedge clk_i) begin
    if (adv_b && va_q) begin
      seg_o   <= pos_b[PW-1:atw_pkg::SpanShift];
      frac_o  <= pos_b[atw_pkg::SpanShift-1:0];
      big_o   <= big_b;
      flags_o <= flags_a_q;
    end
  end

endmodule

[rtl/atw_tanh.sv]
// Piecewise-linear tanh: breakpoint lookup stage and interpolation stage.
module atw_tanh #(
  parameter int unsigned Segments = 64,
  localparam int unsigned SegW = $clog2(Segments)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [SegW-1:0]                    seg_i,
  input  logic [atw_pkg::SpanShift-1:0]      frac_i,
  input  logic                               big_i,
  input  atw_pkg::atw_flags_t                flags_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [atw_pkg::TanhW-1:0]          th_o,
  output atw_pkg::atw_flags_t                flags_o
);

  localparam int unsigned IdxW = $clog2(Segments + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Segments);

  // Breakpoint table, built at elaboration
  logic [atw_pkg::TanhW-1:0] rom [Segments+1];

  for (genvar k = 0; k <= Segments; k++) begin : g_rom
    localparam logic [atw_pkg::TanhW-1:0] Point = atw_pkg::tanh_point(k, Segments);
    assign rom[k] = Point;
  end

  // Stage handshake
  logic vc_q, vd_q;
  logic adv_c, adv_d;

  assign adv_d   = !vd_q || ready_i;
  assign adv_c   = !vc_q || adv_d;
  assign ready_o = adv_c;
  assign valid_o = vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (adv_c) vc_q <= valid_i;
      if (adv_d) vd_q <= vc_q;
    end
  end

  // Stage C: fetch segment ends; past the span, hold the last point
  logic [IdxW-1:0]           idx_lo, idx_hi;
  logic [atw_pkg::TanhW-1:0] lo_c, hi_c, diff_c;

  always_comb begin
    idx_lo = IdxW'(seg_i);
    idx_hi = idx_lo + IdxW'(1);
    lo_c   = rom[idx_lo];
    hi_c   = rom[idx_hi];
    diff_c = (hi_c < lo_c) ? '0 : hi_c - lo_c;
    if (big_i) begin
      lo_c   = rom[LastIdx];
      diff_c = '0;
    end
  end

  logic [atw_pkg::TanhW-1:0]     lo_q, diff_q;
  logic [atw_pkg::SpanShift-1:0] frac_q;
  atw_pkg::atw_flags_t           flags_c_q;

  always_ff @(posedge clk_i) begin
    if (adv_c && valid_i) begin
      lo_q      <= lo_c;
      diff_q    <= diff_c;
      frac_q    <= frac_i;
      flags_c_q <= flags_i;
    end
  end

  // Stage D: interpolate with rounding
  logic [atw_pkg::DiffProdW:0] step_d;

  always_comb begin
    step_d = ({1'b0, {atw_pkg::SpanShift{1'b0}}, diff_q}
              * {1'b0, {atw_pkg::TanhW{1'b0}}, frac_q})
             + (35'd1 << 17);
  end

  always_ff @(posedge clk_i) begin
    if (adv_d && vc_q) begin
      th_o    <= lo_q + step_d[atw_pkg::SpanShift +: atw_pkg::TanhW];
      flags_o <= flags_c_q;
    end
  end

endmodule

[rtl/atw_norm.sv]
// Output stage: normalize the positive branch, apply sign and clipping, hold the word.
module atw_norm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [atw_pkg::TanhW-1:0]            th_i,
  input  atw_pkg::atw_flags_t                  flags_i,
  input  logic [atw_pkg::GainW-1:0]            norm_scale_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [atw_pkg::SampleOutW-1:0] sample_o
);

  logic ve_q;
  logic adv_e;

  assign adv_e   = !ve_q || ready_i;
  assign ready_o = adv_e;
  assign valid_o = ve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (adv_e) begin
      ve_q <= valid_i;
    end
  end

  // Scale by 1/tanh(g), round, saturate to one, then pick by sample class
  logic [atw_pkg::NormProdW-1:0]  prod_e;
  logic [atw_pkg::NormProdW-1:0]  rnd_e;
  logic [atw_pkg::NormProdW-15:0] v_e;
  logic [atw_pkg::TanhW-1:0]      sat_e;
  logic signed [atw_pkg::SampleOutW-1:0] y_e;

  always_comb begin
    prod_e = {16'b0, th_i} * {16'b0, norm_scale_i};
    rnd_e  = prod_e + 32'd8192;
    v_e    = rnd_e[atw_pkg::NormProdW-1:14];
    sat_e  = (v_e > 18'(atw_pkg::OneQ15)) ? atw_pkg::OneQ15 : v_e[atw_pkg::TanhW-1:0];
    if (flags_i.clip_pos) begin
      y_e = 17'sd32768;
    end else if (flags_i.clip_neg) begin
      y_e = -17'sd32768;
    end else if (flags_i.is_zero) begin
      y_e = '0;
    end else if (flags_i.is_pos) begin
      y_e = $signed({1'b0, sat_e});
    end else begin
      y_e = -$signed({1'b0, th_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_e && valid_i) begin
      sample_o <= y_e;
    end
  end

endmodule

[rtl/asymmetric_tanh_waveshaper_top.sv]
// Top level of the asymmetric tanh waveshaper: config registers, pipeline and stream ports.
// One sample in, one shaped sample out, one word per cycle sustained while the output is
// taken. A word passes through five register stages: sign/clip decode with drive multiply,
// segment split, breakpoint lookup, interpolation multiply, and normalize multiply into
// the output register. Each stage moves whenever it is empty or its successor moves, so
// bubbles close up under backpressure and a new word is taken while a finished one waits
// at the output. Samples above +1 give +1, below -1 give -1, positive samples give
// tanh(g*x) scaled by norm_scale and capped at +1, negative ones tanh(x). Write drive_gain
// (index 0, Q8.8) and norm_scale (index 1, Q2.14) only while the pipe is empty.
module asymmetric_tanh_waveshaper_top #(
  parameter int unsigned TANH_SEGMENTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [atw_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [atw_pkg::GainW-1:0]         cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [atw_pkg::TdataInW-1:0]      s_axis_tdata,  // [17:0] sample_in
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [atw_pkg::TdataOutW-1:0]     m_axis_tdata   // [16:0] sample_out
);

  localparam int unsigned SegW = $clog2(TANH_SEGMENTS);

  // Config registers
  logic [atw_pkg::GainW-1:0] drive_gain_q, norm_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q <= 16'd256;
      norm_scale_q <= 16'd21512;
    end else if (cfg_we_i) begin
      case (atw_pkg::atw_cfg_e'(cfg_addr_i))
        atw_pkg::CFG_DRIVE_GAIN: drive_gain_q <= cfg_data_i;
        atw_pkg::CFG_NORM_SCALE: norm_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Drive and segment stages
  logic                          drv_valid, drv_ready;
  logic [SegW-1:0]               drv_seg;
  logic [atw_pkg::SpanShift-1:0] drv_frac;
  logic                          drv_big;
  atw_pkg::atw_flags_t           drv_flags;

  atw_drive #(.Segments(TANH_SEGMENTS)) u_drive (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .sample_i     ($signed(s_axis_tdata[atw_pkg::SampleInW-1:0])),
    .drive_gain_i (drive_gain_q),
    .valid_o      (drv_valid),
    .ready_i      (drv_ready),
    .seg_o        (drv_seg),
    .frac_o       (drv_frac),
    .big_o        (drv_big),
    .flags_o      (drv_flags)
  );

  // Table stages
  logic                      th_valid, th_ready;
  logic [atw_pkg::TanhW-1:0] th_val;
  atw_pkg::atw_flags_t       th_flags;

  atw_tanh #(.Segments(TANH_SEGMENTS)) u_tanh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (drv_valid),
    .ready_o (drv_ready),
    .seg_i   (drv_seg),
    .frac_i  (drv_frac),
    .big_i   (drv_big),
    .flags_i (drv_flags),
    .valid_o (th_valid),
    .ready_i (th_ready),
    .th_o    (th_val),
    .flags_o (th_flags)
  );

  // Output stage
  logic signed [atw_pkg::SampleOutW-1:0] sample_out;

  atw_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (th_valid),
    .ready_o      (th_ready),
    .th_i         (th_val),
    .flags_i      (th_flags),
    .norm_scale_i (norm_scale_q),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .sample_o     (sample_out)
  );

  assign m_axis_tdata = {{(atw_pkg::TdataOutW - atw_pkg::SampleOutW){1'b0}}, sample_out};

  // Result never leaves [-1, +1]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[16:0]) <= 17'sd32768 &&
                       $signed(m_axis_tdata[16:0]) >= -17'sd32768))
    else $error("output sample outside plus or minus one");

  // Input backpressure only when the output word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output side is free");

  // A held output word stays valid until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("held output word dropped");

endmodule

[bench/asymmetric_tanh_waveshaper_top_tb.sv]
// Self-checking testbench for the asymmetric tanh waveshaper top level.
`timescale 1ns / 100ps

module asymmetric_tanh_waveshaper_top_tb;

  localparam int unsigned Segs          = 64;
  localparam int unsigned Latency       = 5;
  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 50;
  localparam int unsigned LongHold      = 80;
  localparam int unsigned NumRows       = 25;

  typedef enum logic {
    ROW_SAMPLE = 1'b0,
    ROW_GAINS  = 1'b1
  } row_kind_e;

  // One directed step: a sample (with an optional literal result) or a gain load
  typedef struct packed {
    row_kind_e                      kind;
    logic signed [17:0]             sample;
    logic [atw_pkg::GainW-1:0]      drive;
    logic [atw_pkg::GainW-1:0]      norm;
    logic                           typed;
    logic signed [16:0]             result;
  } dir_row_t;

  typedef struct packed {
    logic signed [atw_pkg::SampleInW-1:0]  sample;
    logic signed [atw_pkg::SampleOutW-1:0] shaped;
  } shaped_exp_t;

  // Clock, reset and DUT ports
  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [atw_pkg::CfgAddrW-1:0]    cfg_addr_i    = atw_pkg::CFG_DRIVE_GAIN;
  logic [atw_pkg::GainW-1:0]       cfg_data_i    = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [atw_pkg::TdataInW-1:0]    s_axis_tdata  = '0;  // [17:0] sample_in
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [atw_pkg::TdataOutW-1:0]   m_axis_tdata;        // [16:0] sample_out

  // Predictor state: gains as last written, tanh breakpoints
  logic [atw_pkg::GainW-1:0]       drive_q = 16'd256;
  logic [atw_pkg::GainW-1:0]       norm_q  = 16'd21512;
  longint unsigned                 tanh_knots [0:Segs];

  shaped_exp_t            shaped_q [$];
  shaped_exp_t            head_exp;

  int                     send_idle_pct  = 0;
  int                     recv_stall_pct = 0;
  int                     hold_asks      = 0;
  int                     hold_taken     = 0;
  int                     hold_left      = 0;
  int unsigned            quiet_cycles   = 0;
  int                     sent_cnt       = 0;
  int                     checked_cnt    = 0;
  int                     err_cnt        = 0;
  int                     gain_sets      = 0;

  // Directed steps: extremes, clip edges, exactly +/-1, zero drive, saturation
  dir_row_t dir_rows [NumRows] = '{
    '{ROW_SAMPLE, 18'sd0,       16'd0,     16'd0,     1'b1, 17'sd0},
    '{ROW_SAMPLE, 18'sd131071,  16'd0,     16'd0,     1'b1, 17'sd32768},
    '{ROW_SAMPLE, -18'sd131072, 16'd0,     16'd0,     1'b1, -17'sd32768},
    '{ROW_SAMPLE, 18'sd32769,   16'd0,     16'd0,     1'b1, 17'sd32768},
    '{ROW_SAMPLE, -18'sd32769,  16'd0,     16'd0,     1'b1, -17'sd32768},
    '{ROW_SAMPLE, 18'sd32768,   16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, -18'sd32768,  16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, 18'sd1,       16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, -18'sd1,      16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, 18'sd16384,   16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, -18'sd16384,  16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_GAINS,  18'sd0,       16'd0,     16'd21512, 1'b0, 17'sd0},
    '{ROW_SAMPLE, 18'sd32768,   16'd0,     16'd0,     1'b1, 17'sd0},
    '{ROW_SAMPLE, 18'sd1,       16'd0,     16'd0,     1'b1, 17'sd0},
    '{ROW_SAMPLE, -18'sd32768,  16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_GAINS,  18'sd0,       16'd65535, 16'd65535, 1'b0, 17'sd0},
    '{ROW_SAMPLE, 18'sd32768,   16'd0,     16'd0,     1'b1, 17'sd32768},
    '{ROW_SAMPLE, 18'sd1,       16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, 18'sd100000,  16'd0,     16'd0,     1'b1, 17'sd32768},
    '{ROW_GAINS,  18'sd0,       16'd256,   16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, 18'sd16384,   16'd0,     16'd0,     1'b1, 17'sd0},
    '{ROW_GAINS,  18'sd0,       16'd4096,  16'd16384, 1'b0, 17'sd0},
    '{ROW_SAMPLE, 18'sd32767,   16'd0,     16'd0,     1'b0, 17'sd0},
    '{ROW_SAMPLE, -18'sd131071, 16'd0,     16'd0,     1'b1, -17'sd32768},
    '{ROW_GAINS,  18'sd0,       16'd256,   16'd21512, 1'b0, 17'sd0}
  };

  asymmetric_tanh_waveshaper_top #(
    .TANH_SEGMENTS(Segs)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tanh(k/8) in Q15: e^-v by series, to the 16th power, then (1-q)/(1+q)
  function automatic longint unsigned tanh_knot(input longint unsigned k);
    longint unsigned one30, term, ev, q;
    one30 = 64'd1 << 30;
    term  = one30;
    ev    = one30;
    for (int unsigned i = 1; i < 24; i++) begin
      term = (term * k) / (Segs * i);
      ev   = ev + term;
    end
    q = ((64'd1 << 60) + ev / 2) / ev;
    repeat (4) q = (q * q + (64'd1 << 29)) >> 30;
    return (((one30 - q) << 15) + (one30 + q) / 2) / (one30 + q);
  endfunction

  // Piecewise-linear tanh over [0,8) in Q15, one beyond
  function automatic longint unsigned tanh_interp(input longint unsigned t);
    longint unsigned p, seg, frac, lo, hi;
    if (t >= (64'd1 << atw_pkg::SpanShift)) return tanh_knots[Segs];
    p    = t * Segs;
    seg  = p >> atw_pkg::SpanShift;
    if (seg >= Segs) seg = Segs - 1;
    frac = p & ((64'd1 << atw_pkg::SpanShift) - 1);
    lo   = tanh_knots[seg];
    hi   = tanh_knots[seg + 1];
    if (hi < lo) hi = lo;
    return lo + (((hi - lo) * frac + (64'd1 << 17)) >> atw_pkg::SpanShift);
  endfunction

  // Expected shaped sample under the current gains
  function automatic logic signed [atw_pkg::SampleOutW-1:0] shape_sample(
      input logic signed [atw_pkg::SampleInW-1:0] x);
    longint xi, arg, v;
    xi = x;
    if (xi > 32768) return 17'sd32768;
    if (xi < -32768) return -17'sd32768;
    if (xi == 0) return '0;
    if (xi < 0) return -17'(tanh_interp(-xi));
    arg = (longint'(drive_q) * xi + 128) >>> 8;
    v   = (longint'(tanh_interp(arg)) * longint'(norm_q) + 8192) >>> 14;
    if (v > 32768) v = 32768;
    return 17'(v);
  endfunction

  // Mostly the shaped range [-1,+1], plus clip edges, tiny values and full range
  function automatic logic signed [atw_pkg::SampleInW-1:0] rand_sample();
    int v;
    case ($urandom_range(9))
      0, 1:    v = int'($urandom);
      2:       v = 32768 + int'($urandom_range(4)) - 2;
      3:       v = -32768 + int'($urandom_range(4)) - 2;
      4:       v = int'($urandom_range(64)) - 32;
      default: v = int'($urandom_range(65536)) - 32768;
    endcase
    return 18'(v);
  endfunction

  // Offer one word, with random idle cycles first; log the expectation on accept
  task automatic send_sample(input logic signed [atw_pkg::SampleInW-1:0] x,
                             input logic signed [atw_pkg::SampleOutW-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(atw_pkg::TdataInW - atw_pkg::SampleInW){1'b0}}, x};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    shaped_q.push_back('{sample: x, shaped: want});
    sent_cnt++;
  endtask

  // Always advances the clock before it checks, then waits for the pipe to empty
  task automatic wait_drained();
    do @(posedge clk_i); while (shaped_q.size() != 0);
  endtask

  // Stop offering, drain, then write both gain registers
  task automatic load_gains(input logic [atw_pkg::GainW-1:0] drive,
                            input logic [atw_pkg::GainW-1:0] norm);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= atw_pkg::CFG_DRIVE_GAIN;
    cfg_data_i <= drive;
    @(posedge clk_i);
    cfg_addr_i <= atw_pkg::CFG_NORM_SCALE;
    cfg_data_i <= norm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    drive_q  = drive;
    norm_q   = norm;
    gain_sets++;
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_asks != hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LongHold;
      hold_taken    <= hold_asks;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Output check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      checked_cnt++;
      if (shaped_q.size() == 0) begin
        $error("sample_out: no word expected, got %0d",
               $signed(m_axis_tdata[atw_pkg::SampleOutW-1:0]));
        err_cnt++;
      end else begin
        head_exp = shaped_q.pop_front();
        if (m_axis_tdata[atw_pkg::SampleOutW-1:0] !== head_exp.shaped) begin
          $error("sample_out: expected %0d, got %0d (sample_in %0d)",
                 head_exp.shaped, $signed(m_axis_tdata[atw_pkg::SampleOutW-1:0]),
                 head_exp.sample);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("asymmetric_tanh_waveshaper_top: mismatch");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic signed [atw_pkg::SampleInW-1:0]  x;
    logic signed [atw_pkg::SampleOutW-1:0] want;
    logic [atw_pkg::GainW-1:0]             d;
    logic [atw_pkg::GainW-1:0]             n;

    for (int k = 0; k <= Segs; k++) tanh_knots[k] = tanh_knot(k);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_GAINS) begin
        load_gains(dir_rows[r].drive, dir_rows[r].norm);
      end else begin
        if (dir_rows[r].typed) want = dir_rows[r].result;
        else want = shape_sample(dir_rows[r].sample);
        send_sample(dir_rows[r].sample, want);
      end
    end

    // Random phases: one gain setting and one flow-control mix each
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin d = 16'd256;   n = 16'd21512; end
        1: begin d = 16'd0;     n = 16'd21512; end
        2: begin d = 16'd65535; n = 16'd65535; end
        4: begin d = 16'd1280;  n = 16'd16387; end
        5: begin d = 16'd65535; n = 16'd16384; end
        6: begin d = 16'($urandom); n = 16'($urandom); end
        default: begin
          d = 16'($urandom_range(2048, 64));
          n = 16'($urandom_range(65535, 16384));
        end
      endcase
      load_gains(d, n);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // long receiver hold-off while words keep coming: pipe fills, input stalls
        if (p == 4 && i == 10) hold_asks++;
        // sender pause until every word has come out
        if (p == 5 && i == 25) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
        x = rand_sample();
        send_sample(x, shape_sample(x));
      end
    end

    // Drain and let the pipe settle
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (2 * Latency) @(posedge clk_i);

    $display("Shaped %0d samples (%0d directed steps) over %0d gain settings %s",
             sent_cnt, NumRows, gain_sets, "and four idle mixes.");
    $display("Checked %0d output words, %0d mismatches.", checked_cnt, err_cnt);
    if (err_cnt == 0 && shaped_q.size() == 0) begin
      $display("asymmetric_tanh_waveshaper_top: match");
    end else begin
      $display("asymmetric_tanh_waveshaper_top: mismatch");
    end
    $finish;
  end

endmodule
